// ===== sv/swrl_pkg.sv =====
// Shared types and constants for the sliding-log rate limiter.
// No dependencies; imported by every module of the block.
`default_nettype none

package swrl_pkg;

   localparam int SLOTS      = 16;
   localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int COUNT_W    = $clog2(SLOTS + 1);
   localparam int TIME_W     = 32;
   localparam int LIMIT_W    = 5;
   localparam int LIVE_OUT_W = 5;
   localparam int LIVE_MAX   = 31;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_MS = 1'b0,
      CSR_MAX_CALLS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } back_state_type;

   typedef struct packed {
      logic              valid;
      logic [TIME_W-1:0] now_ms;
   } item_type;

   typedef struct packed {
      logic [TIME_W-1:0]  window_ms;
      logic [LIMIT_W-1:0] max_calls;
   } cfg_type;

endpackage

`default_nettype wire

// ===== sv/sliding_window_rate_limiter_unit.sv =====
// Sliding-log rate limiter: one transaction at a time, stepped by the
// single age comparator over 16 slots (pop, scan of every slot, commit).
// The response is registered at commit, which waits while a held response
// is stalled; the two-entry request queue keeps accepting until full.
// Reset (synchronous): log emptied, window_ms = 1000, max_calls = 10.
// Top level; depends on swrl_pkg, swrl_front and swrl_back.
`default_nettype none

module sliding_window_rate_limiter_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [swrl_pkg::TIME_W-1:0]   req_now_ms,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_allowed,
   output logic [swrl_pkg::LIVE_OUT_W-1:0]    rsp_live_count,
   input  wire logic                          csr_we,
   input  wire logic [swrl_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  wire logic [swrl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import swrl_pkg::*;

   logic [TIME_W-1:0]  window_ff;
   logic [LIMIT_W-1:0] max_calls_ff;
   cfg_type            cfg;
   item_type           item;
   logic               pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= TIME_W'(1000);
         max_calls_ff <= LIMIT_W'(10);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_WINDOW_MS: window_ff    <= csr_wdata[TIME_W-1:0];
            CSR_MAX_CALLS: max_calls_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.window_ms = window_ff;
   assign cfg.max_calls = max_calls_ff;

   swrl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_now_ms (req_now_ms),
      .item       (item),
      .pop        (pop)
   );

   swrl_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item           (item),
      .pop            (pop),
      .cfg            (cfg),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_allowed    (rsp_allowed),
      .rsp_live_count (rsp_live_count)
   );

endmodule

`default_nettype wire

// ===== sv/swrl_front.sv =====
// Front end: accepts request transactions into a two-entry queue.
// Depends on swrl_pkg; feeds swrl_back.
`default_nettype none

module swrl_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [swrl_pkg::TIME_W-1:0] req_now_ms,
   output swrl_pkg::item_type             item,
   input  wire logic                      pop
);
   import swrl_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [TIME_W-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              push;
   logic              do_pop;

   assign req_stall   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push        = req_valid && !req_stall;
   assign item.valid  = (count_ff != '0);
   assign item.now_ms = entry_ff[rd_ptr_ff];
   assign do_pop      = pop && item.valid;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_now_ms;
      end
   end

endmodule

`default_nettype wire

// ===== sv/swrl_back.sv =====
// Back end: scans the timestamp log one slot per cycle, expires old stamps,
// admits or refuses the request and holds the response. Depends on swrl_pkg.
`default_nettype none

module swrl_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire swrl_pkg::item_type          item,
   output logic                             pop,
   input  wire swrl_pkg::cfg_type           cfg,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_allowed,
   output logic [swrl_pkg::LIVE_OUT_W-1:0]  rsp_live_count
);
   import swrl_pkg::*;

   back_state_type          state_ff;
   back_state_type          state_in;
   logic [SLOT_IDX_W-1:0]   idx_ff;
   logic [COUNT_W-1:0]      live_ff;
   logic                    found_ff;
   logic [SLOT_IDX_W-1:0]   free_idx_ff;
   logic [TIME_W-1:0]       now_ff;
   logic                    slot_valid_ff [SLOTS];
   logic [TIME_W-1:0]       slot_time_ff  [SLOTS];
   logic                    rsp_valid_ff;
   logic                    rsp_allowed_ff;
   logic [LIVE_OUT_W-1:0]   rsp_live_ff;

   logic [TIME_W-1:0]       age;
   logic                    cur_valid;
   logic                    expired;
   logic                    keep;
   logic                    last;
   logic [COUNT_W-1:0]      limit;
   logic                    admit;
   logic [COUNT_W-1:0]      live_total;
   logic [LIVE_OUT_W-1:0]   live_sat;
   logic                    out_free;
   logic                    commit;

   assign cur_valid = slot_valid_ff[idx_ff];
   assign age       = now_ff - slot_time_ff[idx_ff];
   assign expired   = cur_valid && (age > cfg.window_ms);
   assign keep      = cur_valid && !expired;
   assign last      = (idx_ff == SLOT_IDX_W'(SLOTS - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (32'(cfg.max_calls) > 32'(SLOTS)) begin
         limit = COUNT_W'(SLOTS);
      end else begin
         limit = COUNT_W'(cfg.max_calls);
      end
   end

   assign admit      = found_ff && (live_ff < limit);
   assign live_total = live_ff + COUNT_W'(admit);
   assign live_sat   = (32'(live_total) > 32'(LIVE_MAX)) ? LIVE_OUT_W'(LIVE_MAX)
                                                         : LIVE_OUT_W'(live_total);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item.valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop    = 1'b0;
      commit = 1'b0;
      unique case (state_ff)
         ST_IDLE:   pop    = item.valid;
         ST_SCAN:   ;
         ST_COMMIT: commit = out_free;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_SCAN && expired) begin
            slot_valid_ff[idx_ff] <= 1'b0;
         end
         if (commit && admit) begin
            slot_valid_ff[free_idx_ff] <= 1'b1;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         now_ff   <= item.now_ms;
         idx_ff   <= '0;
         live_ff  <= '0;
         found_ff <= 1'b0;
      end else if (state_ff == ST_SCAN) begin
         idx_ff <= idx_ff + SLOT_IDX_W'(1);
         if (keep) begin
            live_ff <= live_ff + COUNT_W'(1);
         end else if (!found_ff) begin
            found_ff    <= 1'b1;
            free_idx_ff <= idx_ff;
         end
      end
      if (commit) begin
         rsp_allowed_ff <= admit;
         rsp_live_ff    <= live_sat;
         if (admit) begin
            slot_time_ff[free_idx_ff] <= now_ff;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_allowed    = rsp_allowed_ff;
   assign rsp_live_count = rsp_live_ff;

endmodule

`default_nettype wire
